### src/fcs_pkg.sv
`timescale 1ns / 1ps
package fcs_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic {
    CFG_AGING_THR   = 1'b0,
    CFG_FAILED_MASK = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TK_START,
    ST_TK_RD,
    ST_TK_WR,
    ST_TK_NEW,
    ST_RD_DATA,
    ST_QRY_RD,
    ST_QRY_CHK
  } state_e;

  localparam logic [15:0] THR_RESET   = 16'd40;
  localparam logic [7:0]  FMASK_RESET = 8'd1;

  // floor(x / 1000) == (x * SPEED_RECIP) >> SPEED_SHIFT for every x below 2^22.
  localparam logic [41:0] SPEED_RECIP = 42'd1073742;
  localparam int          SPEED_SHIFT = 30;

  typedef struct packed {
    logic [1:0]  operation;
    logic        report_present;
    logic [23:0] report_code;
    logic [7:0]  report_status;
    logic [15:0] speed_rpm;
    logic [15:0] current_ma;
    logic [15:0] voltage_mv;
    logic [7:0]  temp_byte;
    logic [4:0]  entry_index;
    logic [7:0]  status_mask;
    logic [3:0]  max_count;
  } in_t;

  typedef struct packed {
    logic        entry_valid;
    logic [23:0] code;
    logic [7:0]  status;
    logic [15:0] age;
    logic [11:0] frozen_speed;
    logic [15:0] frozen_current;
    logic [15:0] frozen_voltage;
    logic [7:0]  frozen_temp;
    logic [31:0] frozen_time;
    logic [3:0]  count;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [23:0] code;
    logic [7:0]  status;
    logic [15:0] age;
    logic [11:0] speed;
    logic [15:0] current;
    logic [15:0] voltage;
    logic [7:0]  temp;
    logic [31:0] stamp;
  } entry_t;

endpackage

### src/fault_code_store_with_aging_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   in_word_i  (fcs_pkg::in_t)
// out       output     out_valid_o / out_ready_i out_word_o (fcs_pkg::out_t)
// cfg       input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// In a tick, one shared entry unit walks the table entry by entry through a memory with
// one read port and one write port, compacting in place.
// A query stops early once max_count is met.
// Reset empties the table at once; no clearing pass is needed.
// An output register lets the core finish a word while the previous one waits; a word
// that the receiver holds back stalls the core until the output register frees.
module fault_code_store_with_aging_top #(
  parameter int ENTRIES = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [15:0]   cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fcs_pkg::in_t  in_word_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fcs_pkg::out_t out_word_o
);
  import fcs_pkg::*;

  logic res_valid, res_ready, out_valid_q;
  out_t res, out_q;

  fcs_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_hit_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.last |-> out_word_o.entry_valid)
    else $error("non-final word without an entry");

  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.entry_valid |->
      out_word_o.code == 24'd0 && out_word_o.age == 16'd0 && out_word_o.last)
    else $error("status-only word carries entry data");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("new word taken while the previous one is in work");
endmodule

### src/fcs_spd.sv
`timescale 1ns / 1ps
module fcs_spd (
  input  logic        clk_i,
  input  logic [15:0] rpm_i,
  output logic [11:0] speed_o
);
  import fcs_pkg::*;

  logic [21:0] rpm60;
  logic [41:0] prod;
  logic [11:0] speed_q;

  // rpm * 60 as a shift and subtract.
  assign rpm60 = {rpm_i, 6'd0} - {4'd0, rpm_i, 2'd0};
  assign prod  = {20'd0, rpm60} * SPEED_RECIP;

  always_ff @(posedge clk_i) begin
    speed_q <= prod[SPEED_SHIFT+11:SPEED_SHIFT];
  end

  assign speed_o = speed_q;
endmodule

### src/fcs_ctrl.sv
`timescale 1ns / 1ps
module fcs_ctrl #(
  parameter int ENTRIES = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [15:0]   cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fcs_pkg::in_t  in_word_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output fcs_pkg::out_t res_o
);
  import fcs_pkg::*;

  localparam int HW = $clog2(ENTRIES + 1);
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  state_e state_q, state_d;
  in_t item_q, item_d;
  logic [HW-1:0] held_q, held_d, r_q, r_d, w_q, w_d, held_n;
  logic [31:0] ticks_q, ticks_d, last_q, last_d, rep;
  logic [15:0] thr_q;
  logic [7:0] fmask_q;
  logic [3:0] found_q, found_d, done_cnt_q, done_cnt_d;
  logic acc_q, acc_d, hit_q, hit_d;

  entry_t mem [ENTRIES];
  entry_t rd_q, wd, new_e, ev;
  logic [AW-1:0] ra, wa;
  logic we;
  logic upd, aged, drop, app_ok, match, r_lt_held, more_q;
  logic [11:0] speed;

  fcs_spd u_spd (
    .clk_i  (clk_i),
    .rpm_i  (item_q.speed_rpm),
    .speed_o(speed)
  );

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  // Shared per-entry unit: report merge, aging step and threshold compare.
  always_comb begin
    new_e.code    = item_q.report_code;
    new_e.status  = item_q.report_status;
    new_e.age     = 16'd0;
    new_e.speed   = speed;
    new_e.current = item_q.current_ma;
    new_e.voltage = item_q.voltage_mv;
    new_e.temp    = item_q.temp_byte;
    new_e.stamp   = ticks_q;
    upd = acc_q && !hit_q && (rd_q.code == item_q.report_code);
    ev = (state_q == ST_TK_NEW || upd) ? new_e : rd_q;
    aged = (ev.status & fmask_q) == 8'd0;
    if (aged) begin
      ev.age = ev.age + 16'd1;
    end
    drop = aged && (ev.age >= thr_q);
    app_ok = acc_q && !hit_q && (32'(held_q) < 32'(ENTRIES));
    match = (rd_q.status & item_q.status_mask) != 8'd0;
    r_lt_held = r_q < held_q;
    more_q = r_lt_held && (found_q < item_q.max_count);
    rep = {item_q.report_code, item_q.report_status};
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_word_i.operation)
            OP_TICK:  state_d = ST_TK_START;
            OP_READ:  state_d = (32'(in_word_i.entry_index) < 32'(held_q)) ?
                                ST_RD_DATA : ST_TK_NEW;
            OP_QUERY: state_d = ST_QRY_RD;
            default:  state_d = ST_TK_NEW;
          endcase
        end
      end
      ST_TK_START: state_d = ST_TK_RD;
      ST_TK_RD:    state_d = r_lt_held ? ST_TK_WR : ST_TK_NEW;
      ST_TK_WR:    state_d = ST_TK_RD;
      ST_TK_NEW: begin
        // A tick finishes its table pass here; read misses and clears only report.
        if (item_q.operation != OP_TICK && res_ready_i) begin
          state_d = ST_IDLE;
        end else if (item_q.operation == OP_TICK) begin
          state_d = ST_QRY_CHK;
        end
      end
      ST_RD_DATA:  if (res_ready_i) state_d = ST_IDLE;
      ST_QRY_RD:   state_d = more_q ? ST_QRY_CHK : ST_QRY_CHK;
      ST_QRY_CHK: begin
        if (item_q.operation != OP_QUERY || !more_q) begin
          if (res_ready_i) state_d = ST_IDLE;
        end else if (!match || res_ready_i) begin
          state_d = ST_QRY_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    item_d     = item_q;
    held_d     = held_q;
    r_d        = r_q;
    w_d        = w_q;
    ticks_d    = ticks_q;
    last_d     = last_q;
    found_d    = found_q;
    done_cnt_d = done_cnt_q;
    acc_d      = acc_q;
    hit_d      = hit_q;
    held_n     = w_q;
    in_ready_o = 1'b0;
    we         = 1'b0;
    ra         = r_q[AW-1:0];
    wa         = w_q[AW-1:0];
    wd         = ev;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d  = in_word_i;
          r_d     = '0;
          w_d     = '0;
          hit_d   = 1'b0;
          acc_d   = 1'b0;
          found_d = '0;
          case (in_word_i.operation)
            OP_READ: begin
              ra = in_word_i.entry_index[AW-1:0];
              r_d = HW'(in_word_i.entry_index);
              done_cnt_d = 4'(held_q);
            end
            OP_CLEAR: begin
              held_d = '0;
              last_d = '0;
              done_cnt_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_TK_START: begin
        ticks_d = ticks_q + 32'd1;
        if (item_q.report_present && item_q.report_code != 24'd0 && rep != last_q) begin
          acc_d  = 1'b1;
          last_d = rep;
        end
      end
      ST_TK_WR: begin
        if (!drop) begin
          we  = 1'b1;
          w_d = w_q + HW'(1);
        end
        r_d = r_q + HW'(1);
        if (upd) begin
          hit_d = 1'b1;
        end
      end
      ST_TK_NEW: begin
        if (item_q.operation == OP_TICK) begin
          if (app_ok && !drop) begin
            we     = 1'b1;
            held_n = w_q + HW'(1);
          end
          held_d     = held_n;
          done_cnt_d = 4'(held_n);
        end else begin
          res_valid_o = 1'b1;
          res_o.count = done_cnt_q;
          res_o.last  = 1'b1;
        end
      end
      ST_RD_DATA, ST_QRY_CHK: begin
        if (state_q == ST_RD_DATA || (item_q.operation == OP_QUERY && more_q)) begin
          res_o.entry_valid    = 1'b1;
          res_o.code           = rd_q.code;
          res_o.status         = rd_q.status;
          res_o.age            = rd_q.age;
          res_o.frozen_speed   = rd_q.speed;
          res_o.frozen_current = rd_q.current;
          res_o.frozen_voltage = rd_q.voltage;
          res_o.frozen_temp    = rd_q.temp;
          res_o.frozen_time    = rd_q.stamp;
          res_o.count          = 4'(held_q);
          res_o.last           = (state_q == ST_RD_DATA);
          res_valid_o = (state_q == ST_RD_DATA) || match;
          if (state_q == ST_QRY_CHK) begin
            if (match && res_ready_i) begin
              found_d = found_q + 4'd1;
              r_d     = r_q + HW'(1);
            end else if (!match) begin
              r_d = r_q + HW'(1);
            end
          end
        end else begin
          // Final word of a tick or a query.
          res_valid_o = 1'b1;
          res_o.count = (item_q.operation == OP_QUERY) ? found_q : done_cnt_q;
          res_o.last  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      held_q  <= '0;
      ticks_q <= '0;
      last_q  <= '0;
      thr_q   <= THR_RESET;
      fmask_q <= FMASK_RESET;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      ticks_q <= ticks_d;
      last_q  <= last_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_AGING_THR:   thr_q   <= cfg_data_i;
          CFG_FAILED_MASK: fmask_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    r_q        <= r_d;
    w_q        <= w_d;
    found_q    <= found_d;
    done_cnt_q <= done_cnt_d;
    acc_q      <= acc_d;
    hit_q      <= hit_d;
  end
endmodule
